// File: design/quaternion_to_euler_angles_unit_assert.svh
// Assertion macros for the quaternion to Euler angles unit.
// Included by the top level; relies on no other file.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH

// Property checked only while reset is released.
`define QTE_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define QTE_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/qte_pkg.sv
// Shared constants, types and the arctangent table function for the
// quaternion to Euler angles unit. Depends on nothing.
`timescale 1ns / 1ps
package qte_pkg;

    localparam int QTE_COMPONENT_WIDTH = 32;
    localparam int QTE_ANGLE_WIDTH     = 32;
    localparam int QTE_CORDIC_STAGES   = 30;

    // Width of the CORDIC x/y datapath (Q1.30 plus gain headroom).
    localparam int QTE_XW = 34;

    // Turns radians into units of pi/4.
    localparam real QTE_ATAN_SCALE = 1.0 / $atan(1.0);

    // Per-item control that rides alongside a CORDIC operand pair.
    typedef struct packed {
        logic fixed;   // answer is preset, iterations are ignored
        logic tag;     // side flag passed through unchanged
    } t_qte_ctl;

    // atan(2^-idx) in binary angle units, 2^(aw-1) = pi, rounded to nearest.
    function automatic longint qte_atan_entry(input int idx, input int aw);
        real t;
        if (idx == 0) begin
            return longint'(1) << (aw - 3);
        end
        t = $atan(2.0 ** (-idx)) * QTE_ATAN_SCALE * (2.0 ** (aw - 3));
        return longint'(t);
    endfunction

endpackage

// File: design/quaternion_to_euler_angles_unit.sv
// Top level of the quaternion to Euler angles (ZYX) unit.
// Uses qte_pkg, qte_isqrt, qte_cordic and the assertion macro header.
//
// Usage:
//   Slave channel (i_s_*) takes one quaternion per transfer, tdata holding
//   w, x, y, z from the lowest bits up, COMPONENT_WIDTH bits each, signed.
//   Master channel (o_m_*) returns roll, pitch and yaw as signed 32-bit
//   binary angles (2^31 = pi) in tdata, and gimbal_lock in tuser.
//   The input is normalized to Q1.30 (square root and divider pipelines),
//   the angle arguments are formed, pitch takes a second square root, and
//   three CORDIC vectoring pipelines produce the angles.
//   One quaternion can enter every cycle while the receiver does not stall,
//   as the square roots, divider and CORDIC stages are fully pipelined.
//   Reset empties the pipeline: every valid bit clears, no result is pending.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_unit_assert.svh"
module quaternion_to_euler_angles_unit #(
    parameter int COMPONENT_WIDTH = qte_pkg::QTE_COMPONENT_WIDTH,
    parameter int ANGLE_WIDTH     = qte_pkg::QTE_ANGLE_WIDTH,
    parameter int CORDIC_STAGES   = qte_pkg::QTE_CORDIC_STAGES
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // quat_w, quat_x, quat_y, quat_z (lowest bits first), zero padded to bytes
    input  logic [(((4*COMPONENT_WIDTH+7) >> 3) << 3)-1:0] i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // roll [31:0], pitch [63:32], yaw [95:64]
    output logic [95:0]                                 o_m_tdata,
    // gimbal_lock
    output logic                                        o_m_tuser
);
    import qte_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int TW = $clog2(CW);
    localparam int DN = 31;
    localparam int S1W = 4 * 30 + 4 + 1;
    localparam int S2W = 5 * QTE_XW + 2;
    localparam logic [AW-1:0] QTR  = {2'b01, {(AW-2){1'b0}}};
    localparam logic [AW-1:0] NQTR = {2'b11, {(AW-2){1'b0}}};
    localparam logic signed [31:0] QTR32  = 32'($signed(QTR));
    localparam logic signed [31:0] NQTR32 = 32'($signed(NQTR));
    localparam logic signed [36:0] ONE30 = 37'sd1073741824;

    logic w_en;

    // ---------------- stage A: magnitudes ----------------
    logic [CW-1:0] w_comp [4];
    for (genvar k = 0; k < 4; k++) begin : g_comp
        assign w_comp[k] = i_s_tdata[k*CW +: CW];
    end

    logic [CW-1:0] r_a_mag [4];
    logic [3:0]    r_a_neg;
    logic          r_a_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_a_neg[k] <= w_comp[k][CW-1];
                r_a_mag[k] <= w_comp[k][CW-1] ? (~w_comp[k] + 1'b1) : w_comp[k];
            end
        end
    end

    // ---------------- stage B: align top bit to position 29 ----------------
    logic [CW-1:0]  w_all;
    logic [TW-1:0]  w_top;
    logic [CW+28:0] w_ext [4];

    always_comb begin
        w_all = r_a_mag[0] | r_a_mag[1] | r_a_mag[2] | r_a_mag[3];
        w_top = '0;
        for (int i = 0; i < CW; i++) begin
            if (w_all[i]) w_top = TW'(i);
        end
        for (int k = 0; k < 4; k++) begin
            w_ext[k] = {r_a_mag[k], 29'd0} >> w_top;
        end
    end

    logic [29:0] r_b_sm [4];
    logic [3:0]  r_b_neg;
    logic        r_b_zero;
    logic        r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) r_b_sm[k] <= w_ext[k][29:0];
            r_b_neg  <= r_a_neg;
            r_b_zero <= (w_all == '0);
        end
    end

    // ---------------- stage C: squares ----------------
    logic [59:0] r_c_sq [4];
    logic [29:0] r_c_sm [4];
    logic [3:0]  r_c_neg;
    logic        r_c_zero;
    logic        r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_c_sq[k] <= r_b_sm[k] * r_b_sm[k];
                r_c_sm[k] <= r_b_sm[k];
            end
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
        end
    end

    // ---------------- stage D: sum of squares ----------------
    logic [61:0] r_d_sum;
    logic [29:0] r_d_sm [4];
    logic [3:0]  r_d_neg;
    logic        r_d_zero;
    logic        r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_sum <= 62'(r_c_sq[0]) + 62'(r_c_sq[1]) + 62'(r_c_sq[2]) + 62'(r_c_sq[3]);
            r_d_sm  <= r_c_sm;
            r_d_neg <= r_c_neg;
            r_d_zero <= r_c_zero;
        end
    end

    // ---------------- norm = floor(sqrt(sum)) ----------------
    logic [S1W-1:0] w_n_side;
    logic [30:0]    w_n_root;
    logic           w_n_valid;

    qte_isqrt #(
        .RW (31),
        .SW (S1W)
    ) u_norm_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_valid),
        .i_value (r_d_sum),
        .i_side  ({r_d_sm[3], r_d_sm[2], r_d_sm[1], r_d_sm[0], r_d_neg, r_d_zero}),
        .o_valid (w_n_valid),
        .o_root  (w_n_root),
        .o_side  (w_n_side)
    );

    // ---------------- stage E: rounded dividends ----------------
    logic [60:0] r_e_rem [4];
    logic [30:0] r_e_norm;
    logic [3:0]  r_e_neg;
    logic        r_e_zero;
    logic        r_e_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_e_rem[k] <= {1'b0, w_n_side[5 + 30*k +: 30], 30'd0} + 61'(w_n_root[30:1]);
            end
            r_e_norm <= w_n_root;
            r_e_neg  <= w_n_side[4:1];
            r_e_zero <= w_n_side[0];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [60:0] r_dv_rem  [DN][4];
    logic [30:0] r_dv_q    [DN][4];
    logic [30:0] r_dv_norm [DN];
    logic [3:0]  r_dv_neg  [DN];
    logic        r_dv_zero [DN];
    logic        r_dv_valid [DN];

    logic [60:0] w_dv_rem  [DN][4];
    logic [30:0] w_dv_q    [DN][4];
    logic [30:0] w_dv_norm [DN];
    logic [3:0]  w_dv_neg  [DN];
    logic        w_dv_zero [DN];
    logic        w_dv_valid [DN];
    logic [60:0] w_dv_dsh  [DN];

    always_comb begin
        w_dv_rem[0]   = r_e_rem;
        for (int k = 0; k < 4; k++) w_dv_q[0][k] = '0;
        w_dv_norm[0]  = r_e_norm;
        w_dv_neg[0]   = r_e_neg;
        w_dv_zero[0]  = r_e_zero;
        w_dv_valid[0] = r_e_valid;
        for (int j = 1; j < DN; j++) begin
            w_dv_rem[j]   = r_dv_rem[j-1];
            w_dv_q[j]     = r_dv_q[j-1];
            w_dv_norm[j]  = r_dv_norm[j-1];
            w_dv_neg[j]   = r_dv_neg[j-1];
            w_dv_zero[j]  = r_dv_zero[j-1];
            w_dv_valid[j] = r_dv_valid[j-1];
        end
        for (int j = 0; j < DN; j++) begin
            w_dv_dsh[j] = 61'(w_dv_norm[j]) << (DN - 1 - j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DN; j++) r_dv_valid[j] <= 1'b0;
        end else if (w_en) begin
            for (int j = 0; j < DN; j++) r_dv_valid[j] <= w_dv_valid[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < DN; j++) begin
                for (int k = 0; k < 4; k++) begin
                    if (w_dv_rem[j][k] >= w_dv_dsh[j]) begin
                        r_dv_rem[j][k] <= w_dv_rem[j][k] - w_dv_dsh[j];
                        r_dv_q[j][k]   <= w_dv_q[j][k] | (31'd1 << (DN - 1 - j));
                    end else begin
                        r_dv_rem[j][k] <= w_dv_rem[j][k];
                        r_dv_q[j][k]   <= w_dv_q[j][k];
                    end
                end
                r_dv_norm[j] <= w_dv_norm[j];
                r_dv_neg[j]  <= w_dv_neg[j];
                r_dv_zero[j] <= w_dv_zero[j];
            end
        end
    end

    // ---------------- stage F: signed unit quaternion ----------------
    logic signed [31:0] r_f_q [4];
    logic               r_f_valid;
    logic [31:0]        w_f_mag [4];

    always_comb begin
        for (int k = 0; k < 4; k++) w_f_mag[k] = {1'b0, r_dv_q[DN-1][k]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_dv_valid[DN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                if (r_dv_zero[DN-1]) begin
                    r_f_q[k] <= '0;
                end else if (r_dv_neg[DN-1][k]) begin
                    r_f_q[k] <= 32'd0 - w_f_mag[k];
                end else begin
                    r_f_q[k] <= w_f_mag[k];
                end
            end
        end
    end

    // ---------------- stage G: products ----------------
    logic signed [63:0] r_g_wx, r_g_yz, r_g_xx, r_g_yy, r_g_wy;
    logic signed [63:0] r_g_zx, r_g_wz, r_g_xy, r_g_zz, r_g_ww;
    logic               r_g_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_wx <= r_f_q[0] * r_f_q[1];
            r_g_yz <= r_f_q[2] * r_f_q[3];
            r_g_xx <= r_f_q[1] * r_f_q[1];
            r_g_yy <= r_f_q[2] * r_f_q[2];
            r_g_wy <= r_f_q[0] * r_f_q[2];
            r_g_zx <= r_f_q[3] * r_f_q[1];
            r_g_wz <= r_f_q[0] * r_f_q[3];
            r_g_xy <= r_f_q[1] * r_f_q[2];
            r_g_zz <= r_f_q[3] * r_f_q[3];
            r_g_ww <= r_f_q[0] * r_f_q[0];
        end
    end

    // ---------------- stage H: angle arguments ----------------
    function automatic logic signed [36:0] rnd29(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd268435456;
        return 37'(t >>> 29);
    endfunction

    function automatic logic signed [36:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd536870912;
        return 37'(t >>> 30);
    endfunction

    logic signed [36:0] w_roll_a, w_roll_b, w_r, w_yaw_a0, w_yaw_b0;
    logic signed [36:0] w_yaw_a, w_yaw_b;

    always_comb begin
        w_roll_a = rnd29(66'(r_g_wx) + 66'(r_g_yz));
        w_roll_b = ONE30 - rnd29(66'(r_g_xx) + 66'(r_g_yy));
        w_r      = rnd29(66'(r_g_wy) - 66'(r_g_zx));
        w_yaw_a0 = rnd29(66'(r_g_wz) + 66'(r_g_xy));
        w_yaw_b0 = ONE30 - rnd29(66'(r_g_yy) + 66'(r_g_zz));
        w_yaw_a  = w_yaw_a0;
        w_yaw_b  = w_yaw_b0;
        // both yaw arguments vanished: fall back to atan2(2wz, w^2 - z^2)
        if (w_yaw_a0 == '0 && w_yaw_b0 == '0) begin
            w_yaw_a = rnd29(66'(r_g_wz));
            w_yaw_b = rnd30(66'(r_g_ww) - 66'(r_g_zz));
        end
    end

    logic signed [QTE_XW-1:0] r_h_roll_a, r_h_roll_b, r_h_yaw_a, r_h_yaw_b, r_h_r;
    logic                     r_h_clamp, r_h_rpos, r_h_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_en) begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_roll_a <= QTE_XW'(w_roll_a);
            r_h_roll_b <= QTE_XW'(w_roll_b);
            r_h_yaw_a  <= QTE_XW'(w_yaw_a);
            r_h_yaw_b  <= QTE_XW'(w_yaw_b);
            r_h_r      <= QTE_XW'(w_r);
            r_h_clamp  <= (w_r >= ONE30) || (w_r <= -ONE30);
            r_h_rpos   <= (w_r > 0);
        end
    end

    // ---------------- stage I: r squared ----------------
    logic signed [63:0]       r_i_r2;
    logic signed [QTE_XW-1:0] r_i_roll_a, r_i_roll_b, r_i_yaw_a, r_i_yaw_b, r_i_r;
    logic                     r_i_clamp, r_i_rpos, r_i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (w_en) begin
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_r2     <= $signed(r_h_r[31:0]) * $signed(r_h_r[31:0]);
            r_i_roll_a <= r_h_roll_a;
            r_i_roll_b <= r_h_roll_b;
            r_i_yaw_a  <= r_h_yaw_a;
            r_i_yaw_b  <= r_h_yaw_b;
            r_i_r      <= r_h_r;
            r_i_clamp  <= r_h_clamp;
            r_i_rpos   <= r_h_rpos;
        end
    end

    // ---------------- stage J: 1 - r^2 ----------------
    logic [61:0]              r_j_arg;
    logic signed [QTE_XW-1:0] r_j_roll_a, r_j_roll_b, r_j_yaw_a, r_j_yaw_b, r_j_r;
    logic                     r_j_clamp, r_j_rpos, r_j_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (w_en) begin
            r_j_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_arg    <= (62'd1 << 60) - r_i_r2[61:0];
            r_j_roll_a <= r_i_roll_a;
            r_j_roll_b <= r_i_roll_b;
            r_j_yaw_a  <= r_i_yaw_a;
            r_j_yaw_b  <= r_i_yaw_b;
            r_j_r      <= r_i_r;
            r_j_clamp  <= r_i_clamp;
            r_j_rpos   <= r_i_rpos;
        end
    end

    // ---------------- pitch cosine = floor(sqrt(1 - r^2)) ----------------
    logic [S2W-1:0] w_p_side;
    logic [30:0]    w_p_root;
    logic           w_p_valid;

    qte_isqrt #(
        .RW (31),
        .SW (S2W)
    ) u_pitch_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_j_valid),
        .i_value (r_j_arg),
        .i_side  ({r_j_roll_a, r_j_roll_b, r_j_yaw_a, r_j_yaw_b, r_j_r, r_j_clamp, r_j_rpos}),
        .o_valid (w_p_valid),
        .o_root  (w_p_root),
        .o_side  (w_p_side)
    );

    logic signed [QTE_XW-1:0] w_s_roll_a, w_s_roll_b, w_s_yaw_a, w_s_yaw_b, w_s_r;
    logic                     w_s_clamp, w_s_rpos;
    t_qte_ctl                 w_pitch_ctl, w_plain_ctl;

    assign {w_s_roll_a, w_s_roll_b, w_s_yaw_a, w_s_yaw_b, w_s_r, w_s_clamp, w_s_rpos} = w_p_side;
    assign w_pitch_ctl = '{fixed: w_s_clamp, tag: w_s_clamp};
    assign w_plain_ctl = '{fixed: 1'b0, tag: 1'b0};

    // ---------------- CORDIC arctangents ----------------
    logic [AW-1:0] w_roll_z, w_pitch_z, w_yaw_z;
    logic          w_cr_valid, w_gimbal;

    qte_cordic #(
        .AW (AW),
        .NS (CORDIC_STAGES)
    ) u_roll_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_p_valid),
        .i_x       (w_s_roll_b),
        .i_y       (w_s_roll_a),
        .i_ctl     (w_plain_ctl),
        .i_fixed_z ('0),
        .o_valid   (),
        .o_z       (w_roll_z),
        .o_tag     ()
    );

    qte_cordic #(
        .AW (AW),
        .NS (CORDIC_STAGES)
    ) u_pitch_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_p_valid),
        .i_x       (QTE_XW'(w_p_root)),
        .i_y       (w_s_r),
        .i_ctl     (w_pitch_ctl),
        .i_fixed_z (w_s_rpos ? QTR : NQTR),
        .o_valid   (w_cr_valid),
        .o_z       (w_pitch_z),
        .o_tag     (w_gimbal)
    );

    qte_cordic #(
        .AW (AW),
        .NS (CORDIC_STAGES)
    ) u_yaw_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_p_valid),
        .i_x       (w_s_yaw_b),
        .i_y       (w_s_yaw_a),
        .i_ctl     (w_plain_ctl),
        .i_fixed_z ('0),
        .o_valid   (),
        .o_z       (w_yaw_z),
        .o_tag     ()
    );

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic [31:0] r_roll, r_pitch, r_yaw;
    logic        r_gimbal;

    // advance everything unless a finished result is still waiting
    assign w_en = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll   <= 32'($signed(w_roll_z));
            r_pitch  <= 32'($signed(w_pitch_z));
            r_yaw    <= 32'($signed(w_yaw_z));
            r_gimbal <= w_gimbal;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_yaw, r_pitch, r_roll};
    assign o_m_tuser  = r_gimbal;

    // ---------------- assertions ----------------
    `QTE_ASSERT_RST(a_gimbal_pitch, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tdata[63:32] == QTR32 || o_m_tdata[63:32] == NQTR32), "gimbal lock without clamped pitch")
    `QTE_ASSERT_RST(a_stall_freeze, i_clk, i_rst_n, !w_en |=> $stable(r_h_valid) && $stable(r_h_r), "pipeline moved during stall")
    `QTE_ASSERT_RST(a_zero_quat, i_clk, i_rst_n, w_en && r_dv_valid[DN-1] && r_dv_zero[DN-1] |=> r_f_q[0] == '0 && r_f_q[3] == '0, "zero quaternion not kept zero")
    `QTE_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

// File: design/qte_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side word alongside; uses qte_pkg.
`timescale 1ns / 1ps
module qte_isqrt #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_value,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SW-1:0]     o_side
);
    import qte_pkg::*;

    localparam int IW   = 2 * RW;
    localparam int REMW = RW + 3;

    logic [REMW-1:0] r_rem   [RW];
    logic [RW-1:0]   r_root  [RW];
    logic [IW-1:0]   r_val   [RW];
    logic [SW-1:0]   r_side  [RW];
    logic            r_valid [RW];

    logic [REMW-1:0] w_src_rem   [RW];
    logic [RW-1:0]   w_src_root  [RW];
    logic [IW-1:0]   w_src_val   [RW];
    logic [SW-1:0]   w_src_side  [RW];
    logic            w_src_valid [RW];
    logic [REMW-1:0] w_cand      [RW];
    logic [REMW-1:0] w_trial     [RW];

    always_comb begin
        w_src_rem[0]   = '0;
        w_src_root[0]  = '0;
        w_src_val[0]   = i_value;
        w_src_side[0]  = i_side;
        w_src_valid[0] = i_valid;
        for (int k = 1; k < RW; k++) begin
            w_src_rem[k]   = r_rem[k-1];
            w_src_root[k]  = r_root[k-1];
            w_src_val[k]   = r_val[k-1];
            w_src_side[k]  = r_side[k-1];
            w_src_valid[k] = r_valid[k-1];
        end
        for (int k = 0; k < RW; k++) begin
            // bring down the next two bits, try root*4+1
            w_cand[k]  = {w_src_rem[k][REMW-3:0], w_src_val[k][IW-1:IW-2]};
            w_trial[k] = REMW'({w_src_root[k], 2'b01});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) r_valid[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < RW; k++) r_valid[k] <= w_src_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                if (w_cand[k] >= w_trial[k]) begin
                    r_rem[k]  <= w_cand[k] - w_trial[k];
                    r_root[k] <= {w_src_root[k][RW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cand[k];
                    r_root[k] <= {w_src_root[k][RW-2:0], 1'b0};
                end
                r_val[k]  <= {w_src_val[k][IW-3:0], 2'b00};
                r_side[k] <= w_src_side[k];
            end
        end
    end

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: design/qte_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) as a binary angle.
// Handles the axis cases up front; uses qte_pkg for the table and types.
`timescale 1ns / 1ps
module qte_cordic #(
    parameter int AW = qte_pkg::QTE_ANGLE_WIDTH,
    parameter int NS = qte_pkg::QTE_CORDIC_STAGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [qte_pkg::QTE_XW-1:0]  i_x,
    input  logic signed [qte_pkg::QTE_XW-1:0]  i_y,
    input  qte_pkg::t_qte_ctl                  i_ctl,
    input  logic [AW-1:0]                      i_fixed_z,
    output logic                               o_valid,
    output logic [AW-1:0]                      o_z,
    output logic                               o_tag
);
    import qte_pkg::*;

    localparam logic [AW-1:0] HALF = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] QTR  = {2'b01, {(AW-2){1'b0}}};
    localparam logic [AW-1:0] NQTR = {2'b11, {(AW-2){1'b0}}};

    logic [AW-1:0] w_tab [NS];
    for (genvar i = 0; i < NS; i++) begin : g_tab
        assign w_tab[i] = AW'(qte_atan_entry(i, AW));
    end

    logic signed [QTE_XW-1:0] r_x [NS+1];
    logic signed [QTE_XW-1:0] r_y [NS+1];
    logic [AW-1:0]            r_z [NS+1];
    logic [AW-1:0]            r_fz [NS+1];
    logic                     r_fix [NS+1];
    logic                     r_tag [NS+1];
    logic                     r_valid [NS+1];

    logic signed [QTE_XW-1:0] w_x, w_y;
    logic [AW-1:0]            w_z, w_fz;
    logic                     w_fix;

    always_comb begin
        w_fix = i_ctl.fixed;
        w_fz  = i_fixed_z;
        w_x   = i_x;
        w_y   = i_y;
        w_z   = '0;
        if (!i_ctl.fixed) begin
            if (i_y == '0) begin
                w_fix = 1'b1;
                w_fz  = (i_x < 0) ? HALF : '0;
            end else if (i_x == '0) begin
                w_fix = 1'b1;
                w_fz  = (i_y > 0) ? QTR : NQTR;
            end
        end
        // fold the left half plane over and start from pi
        if (i_x < 0) begin
            w_x = -i_x;
            w_y = -i_y;
            w_z = HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_valid[s] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s <= NS; s++) r_valid[s] <= r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= w_x;
            r_y[0]   <= w_y;
            r_z[0]   <= w_z;
            r_fz[0]  <= w_fz;
            r_fix[0] <= w_fix;
            r_tag[0] <= i_ctl.tag;
            for (int s = 1; s <= NS; s++) begin
                if (r_y[s-1] > 0) begin
                    r_x[s] <= r_x[s-1] + (r_y[s-1] >>> (s - 1));
                    r_y[s] <= r_y[s-1] - (r_x[s-1] >>> (s - 1));
                    r_z[s] <= r_z[s-1] + w_tab[s-1];
                end else begin
                    r_x[s] <= r_x[s-1] - (r_y[s-1] >>> (s - 1));
                    r_y[s] <= r_y[s-1] + (r_x[s-1] >>> (s - 1));
                    r_z[s] <= r_z[s-1] - w_tab[s-1];
                end
                r_fz[s]  <= r_fz[s-1];
                r_fix[s] <= r_fix[s-1];
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_valid = r_valid[NS];
    assign o_z     = r_fix[NS] ? r_fz[NS] : r_z[NS];
    assign o_tag   = r_tag[NS];

endmodule

// File: tb/tb_quaternion_to_euler_angles_unit.sv
// Testbench for the quaternion to Euler angles (ZYX) unit: drives quaternions on the
// slave stream, predicts roll, pitch, yaw and gimbal lock in fixed point, checks the
// master stream in order. Depends on qte_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_unit;

    localparam int CW       = qte_pkg::QTE_COMPONENT_WIDTH;
    localparam int AW       = qte_pkg::QTE_ANGLE_WIDTH;
    localparam int STAGES   = qte_pkg::QTE_CORDIC_STAGES;
    localparam int LATENCY  = 105 + STAGES;
    localparam longint ONE30 = 64'sd1 << 30;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        gimbal_lock;
        logic [31:0] yaw;
        logic [31:0] pitch;
        logic [31:0] roll;
    } t_euler;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic         o_m_tuser;

    quaternion_to_euler_angles_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_euler   expected_angles[$];
    int       mismatches = 0;
    longint   cycles = 0;
    bit       idle_enable = 1'b1;
    longint   atan_steps[STAGES];

    // Arctangent table built from integer series, as wide as the angle needs.
    function automatic longint atan_recip_q62(longint unsigned n);
        longint unsigned p, acc, k, t;
        bit neg;
        p = (64'd1 << 62) / n;
        acc = 0;
        k = 1;
        neg = 1'b0;
        while (p != 0) begin
            t = p / k;
            acc = neg ? acc - t : acc + t;
            neg = !neg;
            k += 2;
            p = p / n;
            p = p / n;
        end
        return acc;
    endfunction

    task automatic build_atan_steps();
        longint unsigned quarter_pi, rem, q;
        quarter_pi = 4 * atan_recip_q62(5) - atan_recip_q62(239);
        atan_steps[0] = 64'sd1 << (AW - 3);
        for (int i = 1; i < STAGES; i++) begin
            rem = atan_recip_q62(64'd1 << i);
            q = 0;
            for (int b = 0; b < AW - 2; b++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= quarter_pi) begin
                    rem -= quarter_pi;
                    q |= 1;
                end
            end
            atan_steps[i] = (q + 1) >> 1;
        end
    endtask

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint round_q30(longint v, int n);
        return (v + (64'sd1 << (n - 1))) >>> n;
    endfunction

    function automatic logic [31:0] wrap_angle(longint a);
        logic [AW-1:0] t;
        t = a[AW-1:0];
        return 32'(signed'(t));
    endfunction

    function automatic logic [31:0] cordic_atan2(longint y, longint x);
        longint z, nx;
        z = 0;
        if (y == 0) return wrap_angle(x < 0 ? (64'sd1 << (AW - 1)) : 0);
        if (x == 0) return wrap_angle(y > 0 ? (64'sd1 << (AW - 2)) : -(64'sd1 << (AW - 2)));
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd1 << (AW - 1);
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_steps[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_steps[i];
            end
            x = nx;
        end
        return wrap_angle(z);
    endfunction

    function automatic t_euler predict_euler(logic [127:0] quat);
        longint unsigned mag[4], all_bits, sum, norm;
        bit     neg[4];
        longint q[4], w, x, y, z, a, b, r;
        int     top;
        t_euler res;
        logic [CW-1:0] c;
        all_bits = 0;
        sum = 0;
        top = -1;
        for (int i = 0; i < 4; i++) begin
            c = quat[i*CW +: CW];
            neg[i] = c[CW-1];
            mag[i] = neg[i] ? 64'(-c) & ((64'd1 << CW) - 1) : 64'(c);
            if (neg[i] && mag[i] == 0) mag[i] = 64'd1 << (CW - 1);
            all_bits |= mag[i];
        end
        for (int i = 0; i < 64; i++) if (all_bits[i]) top = i;
        for (int i = 0; i < 4; i++) q[i] = 0;
        if (top >= 0) begin
            for (int i = 0; i < 4; i++) begin
                mag[i] = top > 29 ? mag[i] >> (top - 29) : mag[i] << (29 - top);
                sum += mag[i] * mag[i];
            end
            norm = isqrt(sum);
            for (int i = 0; i < 4; i++) begin
                q[i] = longint'(((mag[i] << 30) + (norm >> 1)) / norm);
                if (neg[i]) q[i] = -q[i];
            end
        end
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        a = round_q30(w * x + y * z, 29);
        b = ONE30 - round_q30(x * x + y * y, 29);
        res.roll = cordic_atan2(a, b);
        r = round_q30(w * y - z * x, 29);
        if (r >= ONE30 || r <= -ONE30) begin
            res.pitch = wrap_angle(r > 0 ? (64'sd1 << (AW - 2)) : -(64'sd1 << (AW - 2)));
            res.gimbal_lock = 1'b1;
        end else begin
            res.pitch = cordic_atan2(r, longint'(isqrt(64'(ONE30 * ONE30 - r * r))));
            res.gimbal_lock = 1'b0;
        end
        a = round_q30(w * z + x * y, 29);
        b = ONE30 - round_q30(y * y + z * z, 29);
        if (a == 0 && b == 0) begin
            a = round_q30(w * z, 29);
            b = round_q30(w * w - z * z, 30);
        end
        res.yaw = cordic_atan2(a, b);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, want %h", field, got, want);
        mismatches++;
    endtask

    // Drop tvalid for a random burst of idle cycles.
    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Send one quaternion and queue its expected angles.
    task automatic send_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [127:0] quat;
        quat = {z, y, x, w};
        random_gap();
        i_s_tdata  <= quat;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_angles.push_back(predict_euler(quat));
    endtask

    // Receiver stall pattern: bursts of low tready.
    always @(posedge i_clk) begin
        if (!idle_enable || $urandom_range(0, 5) != 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_euler want;
        cycles++;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected transfer", o_m_tdata[31:0], 32'd0);
            end else begin
                want = expected_angles.pop_front();
                if (o_m_tdata[31:0] !== want.roll) report_mismatch("roll", o_m_tdata[31:0], want.roll);
                if (o_m_tdata[63:32] !== want.pitch)
                    report_mismatch("pitch", o_m_tdata[63:32], want.pitch);
                if (o_m_tdata[95:64] !== want.yaw) report_mismatch("yaw", o_m_tdata[95:64], want.yaw);
                if (o_m_tuser !== want.gimbal_lock)
                    report_mismatch("gimbal_lock", 32'(o_m_tuser), 32'(want.gimbal_lock));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            2: return $urandom >> $urandom_range(0, 31);
            default: return -($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    task automatic test_extremes();
        send_quat(0, 0, 0, 0);
        send_quat(32'h7fffffff, 0, 0, 0);
        send_quat(32'h80000000, 0, 0, 0);
        send_quat(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_quat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_quat(32'hffffffff, 1, 32'hffffffff, 1);
        send_quat(0, 1, 0, 0);
        send_quat(0, 0, 0, 1);
        send_quat(0, 0, 0, 32'hffffffff);
        send_quat(0, 0, 1, 0);
    endtask

    // Gimbal lock at both signs and the yaw fallback when its arguments vanish.
    task automatic test_gimbal_and_yaw_fallback();
        send_quat(1, 0, 1, 0);
        send_quat(1, 0, 32'hffffffff, 0);
        send_quat(1000, 1000, 1000, 32'hfffffc18);
        send_quat(1000, 32'hfffffc18, 1000, 1000);
        send_quat(32'h40000000, 0, 32'h40000000, 0);
        send_quat(5, 0, 5, 0);
        send_quat(3, 0, 0, 4);
        send_quat(0, 7, 7, 0);
        send_quat(123456, 654321, 32'hffff0000, 42);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                // Near gimbal lock: w ~ y, x ~ -z.
                logic [31:0] w, x;
                w = rand_comp();
                x = rand_comp() >>> 8;
                send_quat(w, x, w + $urandom_range(0, 2), -x);
            end else begin
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
        end
    endtask

    initial begin
        build_atan_steps();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_gimbal_and_yaw_fallback();
        test_random(480);
        idle_enable = 1'b0;
        test_random(120);
        i_s_tvalid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/qte_pkg.sv
design/qte_isqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_angles_unit.sv
tb/tb_quaternion_to_euler_angles_unit.sv
